// File: rtl/assert_macros.svh
// shared assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

  // frame table depth and index width
  localparam int MAX_FRAMES = 64;
  localparam int FRAME_AW   = $clog2(MAX_FRAMES);
  localparam int CNT_W      = 7;
  localparam logic [15:0] SCALE_ONE = 16'd256;

  typedef logic [FRAME_AW-1:0] frame_idx_t;

  // request kinds carried in tuser
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_LOAD  = 3'd1,
    REQ_START = 3'd2,
    REQ_SET   = 3'd3,
    REQ_STOP  = 3'd4,
    REQ_PLAY  = 3'd5
  } req_t;

  // reported playback status
  typedef enum logic [2:0] {
    ST_STARTED    = 3'd0,
    ST_PLAYING    = 3'd1,
    ST_ADVANCED   = 3'd2,
    ST_LOOP_RESET = 3'd3,
    ST_LOCKED     = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_LOOPED      = 2'd1,
    CFG_REVERSE     = 2'd2,
    CFG_TIME_SCALE  = 2'd3
  } cfg_idx_t;

  // one frame table entry
  typedef struct packed {
    logic [15:0]        duration;
    logic [15:0]        flags;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } frame_entry_t;

  // frame count clamped to 1..MAX_FRAMES, minus one
  function automatic frame_idx_t last_frame(logic [CNT_W-1:0] cnt);
    frame_idx_t res;
    if (cnt == '0) begin
      res = '0;
    end else if (int'(cnt) > MAX_FRAMES) begin
      res = FRAME_AW'(MAX_FRAMES - 1);
    end else begin
      res = FRAME_AW'(cnt - 1'b1);
    end
    return res;
  endfunction

  // pointer clamped to the last frame
  function automatic frame_idx_t sat_frame(frame_idx_t idx, logic [CNT_W-1:0] cnt);
    frame_idx_t last;
    last = last_frame(cnt);
    return (idx > last) ? last : idx;
  endfunction

  // frame entered after completing frame fp (fp when locking at the end)
  function automatic frame_idx_t step_frame(frame_idx_t fp, logic [CNT_W-1:0] cnt,
                                            logic rev, logic loop_en);
    frame_idx_t last;
    frame_idx_t res;
    last = last_frame(cnt);
    if (rev) begin
      if (fp == '0) res = loop_en ? last : fp;
      else          res = fp - 1'b1;
    end else begin
      if (fp == last) res = loop_en ? '0 : fp;
      else            res = fp + 1'b1;
    end
    return res;
  endfunction

endpackage

// File: rtl/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    tuser: req_type; tdata: request fields (88 bits)
// out_     out  out_tvalid/tready   tdata: frame, status, event, position (96 bits)
// cfg_     in   cfg_we              cfg_addr register index, cfg_data value
//
// one word per cycle sustained while the output is not stalled; each executed word's result is registered
// the word register feeds one pass of multiply, saturating add, compare and step
// the frame table is read every cycle at the pointer the next state will hold,
// on two ports (current frame, frame that would be entered), read data registered
// rst_n is synchronous; the frame table is not cleared
// a stalled output holds the input word register, which then drops in_tready
`include "assert_macros.svh"

module sprite_frame_sequencer import sfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] delta_time, [16] update_pos, [22:17] frame_index, [38:23] frame_duration,
  // [54:39] frame_flags, [70:55] frame_dx, [86:71] frame_dy, [87] rewind
  input  logic [87:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] current_frame, [8:6] play_status, [24:9] frame_event,
  // [56:25] position_x, [88:57] position_y, [95:89] zero
  output logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  // input word register
  logic         s1_valid_r;
  req_t         s1_req_r;
  logic [15:0]  s1_delta_r;
  logic         s1_upd_r;
  logic [5:0]   s1_idx_r;
  frame_entry_t s1_entry_r;
  logic         s1_rewind_r;
  logic         s1_exec;

  // sequencer state and configuration
  frame_idx_t         fp_r, fp_nxt;
  status_t            status_r, status_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               looped_r, looped_nxt;
  logic               reverse_r, reverse_nxt;
  logic [15:0]        scale_r, scale_nxt;

  // result register
  logic         out_valid_r;
  logic [15:0]  event_r, event_nxt;

  // frame table
  frame_entry_t tbl_mem [MAX_FRAMES];
  frame_entry_t rd_a_r;
  logic [15:0]  flags_b_r;
  frame_idx_t   rd_addr, rd_step;
  logic         mem_we;
  frame_idx_t   mem_waddr;

  // tick datapath
  frame_idx_t   last_idx, fp_sat, step_idx;
  logic         at_end;
  logic [31:0]  product;
  logic [32:0]  sum;
  logic [31:0]  acc_sat, need;
  logic         adv;

  // conditions named by the checks
  logic         s1_frame_req;
  logic         s1_locked_tick;
  logic         locked_quiet;

  assign s1_exec   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_exec;

  // input word capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_req_r            <= req_t'(in_tuser);
      s1_delta_r          <= in_tdata[15:0];
      s1_upd_r            <= in_tdata[16];
      s1_idx_r            <= in_tdata[22:17];
      s1_entry_r.duration <= in_tdata[38:23];
      s1_entry_r.flags    <= in_tdata[54:39];
      s1_entry_r.dx       <= in_tdata[70:55];
      s1_entry_r.dy       <= in_tdata[86:71];
      s1_rewind_r         <= in_tdata[87];
    end
  end

  // tick arithmetic on the current frame
  assign last_idx = last_frame(count_r);
  assign fp_sat   = sat_frame(fp_r, count_r);
  assign step_idx = step_frame(fp_sat, count_r, reverse_r, looped_r);
  assign at_end   = reverse_r ? (fp_sat == '0) : (fp_sat == last_idx);
  assign product  = 32'(s1_delta_r) * 32'(scale_r);
  assign sum      = {1'b0, acc_r} + {1'b0, product};
  assign acc_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign need     = {rd_a_r.duration, 16'h0000};
  assign adv      = (acc_sat >= need);

  // next state for the word being executed and for configuration writes
  always_comb begin
    fp_nxt      = fp_r;
    status_nxt  = status_r;
    acc_nxt     = acc_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    count_nxt   = count_r;
    looped_nxt  = looped_r;
    reverse_nxt = reverse_r;
    scale_nxt   = scale_r;
    event_nxt   = event_r;
    mem_we      = 1'b0;
    mem_waddr   = FRAME_AW'(s1_idx_r);

    if (s1_exec) begin
      event_nxt = '0;
      case (s1_req_r)
        REQ_TICK: begin
          fp_nxt = fp_sat;
          if (status_r != ST_LOCKED) begin
            if (status_r == ST_STARTED) event_nxt = rd_a_r.flags;
            status_nxt = ST_PLAYING;
            acc_nxt    = acc_sat;
            if (adv) begin
              acc_nxt = acc_sat - need;
              if (s1_upd_r) begin
                pos_x_nxt = pos_x_r + {{16{rd_a_r.dx[15]}}, rd_a_r.dx};
                pos_y_nxt = pos_y_r + {{16{rd_a_r.dy[15]}}, rd_a_r.dy};
              end
              if (!at_end)       status_nxt = ST_ADVANCED;
              else if (looped_r) status_nxt = ST_LOOP_RESET;
              else               status_nxt = ST_LOCKED;
              fp_nxt    = step_idx;
              event_nxt = flags_b_r;
            end
          end
        end
        REQ_LOAD: begin
          mem_we = (int'(s1_idx_r) < MAX_FRAMES);
        end
        REQ_START: begin
          acc_nxt     = '0;
          scale_nxt   = SCALE_ONE;
          reverse_nxt = 1'b0;
          fp_nxt      = sat_frame(FRAME_AW'(s1_idx_r), count_r);
          status_nxt  = ST_STARTED;
        end
        REQ_SET: begin
          fp_nxt  = sat_frame(FRAME_AW'(s1_idx_r), count_r);
          acc_nxt = '0;
        end
        REQ_STOP: begin
          status_nxt = ST_LOCKED;
        end
        REQ_PLAY: begin
          status_nxt = ST_STARTED;
          if (s1_rewind_r) fp_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    // configuration writes
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FRAME_COUNT: count_nxt   = cfg_data[CNT_W-1:0];
        CFG_LOOPED:      looped_nxt  = cfg_data[0];
        CFG_REVERSE:     reverse_nxt = cfg_data[0];
        CFG_TIME_SCALE:  scale_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // table addresses follow the state the next word will see
  assign rd_addr = sat_frame(fp_nxt, count_nxt);
  assign rd_step = step_frame(rd_addr, count_nxt, reverse_nxt, looped_nxt);

  // frame table, write-first on both read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= s1_entry_r;
    end
    if (mem_we && (mem_waddr == rd_addr)) rd_a_r <= s1_entry_r;
    else                                  rd_a_r <= tbl_mem[rd_addr];
    if (mem_we && (mem_waddr == rd_step)) flags_b_r <= s1_entry_r.flags;
    else                                  flags_b_r <= tbl_mem[rd_step].flags;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r        <= '0;
      status_r    <= ST_STARTED;
      acc_r       <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      count_r     <= CNT_W'(1);
      looped_r    <= 1'b0;
      reverse_r   <= 1'b0;
      scale_r     <= SCALE_ONE;
      out_valid_r <= 1'b0;
    end else begin
      fp_r        <= fp_nxt;
      status_r    <= status_nxt;
      acc_r       <= acc_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      count_r     <= count_nxt;
      looped_r    <= looped_nxt;
      reverse_r   <= reverse_nxt;
      scale_r     <= scale_nxt;
      if (s1_exec)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    event_r <= event_nxt;
  end

  // result word: state holds until the next word executes
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, pos_y_r, pos_x_r, event_r, status_r, 6'(fp_r)};

  // checks
  assign s1_frame_req   = s1_req_r inside {REQ_TICK, REQ_START, REQ_SET};
  assign s1_locked_tick = s1_exec && (s1_req_r == REQ_TICK) && (status_r == ST_LOCKED);
  assign locked_quiet   = (status_r == ST_LOCKED) && (event_r == '0);

  `ASSERT_NEXT(a_exec_gives_result, s1_exec, out_valid_r, "executed word produced no result")
  `ASSERT_NEXT(a_frame_in_range, s1_exec && s1_frame_req, fp_r <= last_idx, "frame beyond count")
  `ASSERT_NEXT(a_locked_tick_quiet, s1_locked_tick, locked_quiet, "locked tick changed state")
  `ASSERT_CLK(a_stall_blocks_input, !in_tready |-> out_valid_r, "input stalled while output free")

endmodule
